// File: design/atac_pkg.sv
`timescale 1ns / 1ps
// Package for the anchor target assigner: shared types, constants and helper functions.
// Depends on nothing; every design file refers to it by scoped names.
package atac_pkg;

    localparam int NUM_ANCHOR_SLOTS_DEF = 3;
    localparam int RATIO_LIMIT_Q8_DEF   = 1024;
    localparam int CLASS_COUNT_DEF      = 80;
    localparam int MAX_BATCH_DEF        = 64;

    localparam int MAX_SLOTS   = 3;
    localparam int SLOT_W      = 2;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 16;
    localparam int DIV_STAGES  = 4;
    localparam int DIV_STEPS   = 4;
    localparam int LIM_W       = 13;
    localparam logic [14:0] RATIO_MAX = 15'h7FFF;

    // Configuration register indices.
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_W = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_H = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_A0_W   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_A0_H   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_A1_W   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_A1_H   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_A2_W   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_A2_H   = 4'd7;

    localparam logic [8:0]  GRID_RST = 9'd80;
    localparam logic [15:0] ANC_W_RST [MAX_SLOTS] = '{16'd320, 16'd512, 16'd1056};
    localparam logic [15:0] ANC_H_RST [MAX_SLOTS] = '{16'd416, 16'd960, 16'd736};

    typedef struct packed {
        logic [5:0]  batch;
        logic [7:0]  cls;
        logic [15:0] cx;
        logic [15:0] cy;
        logic [15:0] bw;
        logic [15:0] bh;
    } box_t;

    typedef struct packed {
        logic [SLOT_W-1:0] anchor;
        logic [7:0]  cell_x;
        logic [7:0]  cell_y;
        logic [15:0] row;
        logic [23:0] flat;
        logic [15:0] off_x;
        logic [15:0] off_y;
        logic [7:0]  cls;
        logic        cls_ok;
        logic        last;
        logic        keep;
    } slot_t;

    typedef struct packed {
        logic [15:0] num_lo;
        logic [15:0] rem;
        logic [15:0] quo;
        logic [15:0] den;
        logic        ovf;
    } div_t;

    function automatic logic [8:0] clamp_grid(input logic [8:0] g);
        logic [8:0] r;
        r = g;
        if (g == 9'd0)
            r = 9'd1;
        else if (g > 9'd256)
            r = 9'd256;
        return r;
    endfunction

    // True when the box size lies within the ratio limit of the anchor size, bounds included.
    function automatic logic ratio_pass(input logic [23:0] sz, input logic [15:0] anc,
                                       input logic [LIM_W-1:0] lim);
        logic [39:0] anc_lim;
        logic [39:0] sz_lim;
        logic [39:0] anc_sh;
        anc_lim = 40'(anc) * 40'(lim);
        sz_lim  = 40'(sz) * 40'(lim);
        anc_sh  = {8'd0, anc, 16'd0};
        return (anc != 16'd0) && (sz != 24'd0) && (40'(sz) <= anc_lim) && (anc_sh <= sz_lim);
    endfunction

endpackage

// File: design/atac_issue.sv
`timescale 1ns / 1ps
// Input holding register of the anchor target assigner: keeps one box and issues one anchor
// slot per advancing cycle. Depends on atac_pkg.
module atac_issue #(
    parameter int NUM_ANCHOR_SLOTS = atac_pkg::NUM_ANCHOR_SLOTS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  atac_pkg::box_t             in_box,
    input  logic                       adv,
    output logic                       slot_valid,
    output atac_pkg::box_t             slot_box,
    output logic [atac_pkg::SLOT_W-1:0] slot_anchor
);

    logic                        busy_reg, busy_next;
    logic [atac_pkg::SLOT_W-1:0] slot_reg, slot_next;
    atac_pkg::box_t              box_reg, box_next;
    logic                        final_slot;

    assign final_slot = (slot_reg == atac_pkg::SLOT_W'(NUM_ANCHOR_SLOTS - 1));
    assign in_ready   = !busy_reg || (adv && final_slot);

    always_comb
    begin
        busy_next = busy_reg;
        slot_next = slot_reg;
        box_next  = box_reg;
        if (busy_reg && adv)
        begin
            if (final_slot)
            begin
                busy_next = 1'b0;
                slot_next = '0;
            end
            else
            begin
                slot_next = slot_reg + 1'b1;
            end
        end
        if (in_valid && in_ready)
        begin
            busy_next = 1'b1;
            slot_next = '0;
            box_next  = in_box;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            slot_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            slot_reg <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        box_reg <= box_next;
    end

    assign slot_valid  = busy_reg;
    assign slot_box    = box_reg;
    assign slot_anchor = slot_reg;

endmodule

// File: design/atac_div_stage.sv
`timescale 1ns / 1ps
// One registered stage of the restoring ratio divider: DIV_STEPS (four) quotient bits per stage.
// Depends on atac_pkg.
module atac_div_stage (
    input  logic           clk,
    input  logic           adv,
    input  atac_pkg::div_t div_in,
    output atac_pkg::div_t div_out
);

    atac_pkg::div_t div_reg, div_next;

    always_comb
    begin
        logic [16:0] trial;
        div_next = div_in;
        for (int i = 0; i < atac_pkg::DIV_STEPS; i++)
        begin
            trial = {div_next.rem, div_next.num_lo[15]};
            div_next.num_lo = {div_next.num_lo[14:0], 1'b0};
            if (trial >= {1'b0, div_next.den})
            begin
                div_next.rem = 16'(trial - {1'b0, div_next.den});
                div_next.quo = {div_next.quo[14:0], 1'b1};
            end
            else
            begin
                div_next.rem = trial[15:0];
                div_next.quo = {div_next.quo[14:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            div_reg <= div_next;
    end

    assign div_out = div_reg;

endmodule

// File: design/anchor_target_assigner_core.sv
`timescale 1ns / 1ps
// Anchor target assigner: matches one ground-truth box against the anchors of one scale.
// A box passes the issue register, stages 1 and 2, the divider stages and the output register;
// only words of passing anchors are shown. The single issue slot feeds one anchor per cycle
// while the pipeline advances, taking a new box as the held box's last slot issues. Reset
// (rst_n, asynchronous, low) empties the pipeline and loads the default grid and anchor sizes.
module anchor_target_assigner_core #(
    parameter int NUM_ANCHOR_SLOTS = atac_pkg::NUM_ANCHOR_SLOTS_DEF,
    parameter int RATIO_LIMIT_Q8   = atac_pkg::RATIO_LIMIT_Q8_DEF,
    parameter int CLASS_COUNT      = atac_pkg::CLASS_COUNT_DEF,
    parameter int MAX_BATCH        = atac_pkg::MAX_BATCH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [atac_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [atac_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [5:0]  batch_index,
    input  logic [7:0]  class_id,
    input  logic [15:0] box_center_x,
    input  logic [15:0] box_center_y,
    input  logic [15:0] box_width,
    input  logic [15:0] box_height,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  anchor_index,
    output logic [7:0]  cell_x,
    output logic [7:0]  cell_y,
    output logic [23:0] flat_index,
    output logic [15:0] offset_x,
    output logic [15:0] offset_y,
    output logic [14:0] width_ratio,
    output logic [14:0] height_ratio,
    output logic [7:0]  class_out,
    output logic        class_valid,
    output logic        last
);

    localparam int S = atac_pkg::MAX_SLOTS;
    localparam int D = atac_pkg::DIV_STAGES;

    // Configuration registers. The port never stalls.
    logic [8:0]  grid_w_reg, grid_h_reg;
    logic [15:0] anc_w_reg [S];
    logic [15:0] anc_h_reg [S];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_w_reg <= atac_pkg::GRID_RST;
            grid_h_reg <= atac_pkg::GRID_RST;
            for (int k = 0; k < S; k++)
            begin
                anc_w_reg[k] <= atac_pkg::ANC_W_RST[k];
                anc_h_reg[k] <= atac_pkg::ANC_H_RST[k];
            end
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                atac_pkg::CFG_GRID_W: grid_w_reg   <= cfg_data[8:0];
                atac_pkg::CFG_GRID_H: grid_h_reg   <= cfg_data[8:0];
                atac_pkg::CFG_A0_W:   anc_w_reg[0] <= cfg_data;
                atac_pkg::CFG_A0_H:   anc_h_reg[0] <= cfg_data;
                atac_pkg::CFG_A1_W:   anc_w_reg[1] <= cfg_data;
                atac_pkg::CFG_A1_H:   anc_h_reg[1] <= cfg_data;
                atac_pkg::CFG_A2_W:   anc_w_reg[2] <= cfg_data;
                atac_pkg::CFG_A2_H:   anc_h_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // The whole pipeline moves together; it halts only when the output word is held up.
    logic out_valid_reg;
    logic adv;
    assign adv = !out_valid_reg || out_ready;

    // Issue: one anchor slot of the held box per cycle while the pipeline advances.
    atac_pkg::box_t              in_box, slot_box;
    logic                        slot_valid;
    logic [atac_pkg::SLOT_W-1:0] slot_anchor;

    assign in_box = '{batch: batch_index, cls: class_id, cx: box_center_x,
                      cy: box_center_y, bw: box_width, bh: box_height};

    atac_issue #(
        .NUM_ANCHOR_SLOTS(NUM_ANCHOR_SLOTS)
    ) u_issue (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_box     (in_box),
        .adv        (adv),
        .slot_valid (slot_valid),
        .slot_box   (slot_box),
        .slot_anchor(slot_anchor)
    );

    // Stage 1: scale the box to grid units. Every product is at most 24 bits wide.
    logic                        s1_valid_reg;
    logic [atac_pkg::SLOT_W-1:0] s1_anchor_reg;
    logic [7:0]  s1_cls_reg;
    logic        s1_bok_reg;
    logic [7:0]  s1_bc_reg;
    logic [8:0]  s1_gw_reg, s1_gh_reg;
    logic [23:0] s1_cxg_reg, s1_cyg_reg, s1_wg_reg, s1_hg_reg;
    logic [8:0]  gw_c, gh_c;

    assign gw_c = atac_pkg::clamp_grid(grid_w_reg);
    assign gh_c = atac_pkg::clamp_grid(grid_h_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= slot_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_anchor_reg <= slot_anchor;
            s1_cls_reg    <= slot_box.cls;
            s1_bok_reg    <= (32'(slot_box.batch) < 32'(MAX_BATCH));
            s1_bc_reg     <= 8'(8'(slot_box.batch) * 8'(NUM_ANCHOR_SLOTS) + 8'(slot_anchor));
            s1_gw_reg     <= gw_c;
            s1_gh_reg     <= gh_c;
            s1_cxg_reg    <= 24'(slot_box.cx * gw_c);
            s1_cyg_reg    <= 24'(slot_box.cy * gh_c);
            s1_wg_reg     <= 24'(slot_box.bw * gw_c);
            s1_hg_reg     <= 24'(slot_box.bh * gh_c);
        end
    end

    // Stage 2: clamp the cell, decide the anchor tests, seed the dividers.
    logic [7:0]  gx_raw, gy_raw, gx_max, gy_max, gx, gy;
    logic [S-1:0] pass_vec;
    logic        later_pass;
    logic [15:0] aw_sel, ah_sel;
    atac_pkg::slot_t s2_slot;
    atac_pkg::div_t  s2_div_w, s2_div_h;

    assign gx_raw = s1_cxg_reg[23:16];
    assign gy_raw = s1_cyg_reg[23:16];
    assign gx_max = 8'(s1_gw_reg - 9'd1);
    assign gy_max = 8'(s1_gh_reg - 9'd1);
    assign gx     = (gx_raw > gx_max) ? gx_max : gx_raw;
    assign gy     = (gy_raw > gy_max) ? gy_max : gy_raw;
    assign aw_sel = anc_w_reg[s1_anchor_reg];
    assign ah_sel = anc_h_reg[s1_anchor_reg];

    always_comb
    begin
        later_pass = 1'b0;
        for (int k = 0; k < S; k++)
        begin
            pass_vec[k] = (k < NUM_ANCHOR_SLOTS)
                && atac_pkg::ratio_pass(s1_wg_reg, anc_w_reg[k],
                                        atac_pkg::LIM_W'(RATIO_LIMIT_Q8))
                && atac_pkg::ratio_pass(s1_hg_reg, anc_h_reg[k],
                                        atac_pkg::LIM_W'(RATIO_LIMIT_Q8));
            if (pass_vec[k] && (atac_pkg::SLOT_W'(k) > s1_anchor_reg))
                later_pass = 1'b1;
        end
    end

    always_comb
    begin
        s2_slot.anchor = s1_anchor_reg;
        s2_slot.cell_x = gx;
        s2_slot.cell_y = gy;
        s2_slot.row    = 16'(s1_bc_reg * s1_gh_reg + 17'(gy));
        s2_slot.flat   = '0;
        s2_slot.off_x  = 16'(s1_cxg_reg - {gx, 16'd0});
        s2_slot.off_y  = 16'(s1_cyg_reg - {gy, 16'd0});
        s2_slot.cls    = s1_cls_reg;
        s2_slot.cls_ok = (32'(s1_cls_reg) < 32'(CLASS_COUNT));
        s2_slot.keep   = s1_bok_reg && pass_vec[s1_anchor_reg];
        s2_slot.last   = !later_pass;

        // The dividend is the Q.16 size shifted left by four; its top twelve bits seed the
        // remainder, and a seed not below the divisor already means saturation.
        s2_div_w.num_lo = {s1_wg_reg[11:0], 4'd0};
        s2_div_w.rem    = 16'(s1_wg_reg[23:12]);
        s2_div_w.quo    = '0;
        s2_div_w.den    = aw_sel;
        s2_div_w.ovf    = (16'(s1_wg_reg[23:12]) >= aw_sel);
        s2_div_h.num_lo = {s1_hg_reg[11:0], 4'd0};
        s2_div_h.rem    = 16'(s1_hg_reg[23:12]);
        s2_div_h.quo    = '0;
        s2_div_h.den    = ah_sel;
        s2_div_h.ovf    = (16'(s1_hg_reg[23:12]) >= ah_sel);
    end

    logic            s2_valid_reg;
    atac_pkg::slot_t s2_slot_reg;
    atac_pkg::div_t  s2_div_w_reg, s2_div_h_reg;
    logic [8:0]      s2_gw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (adv)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_slot_reg  <= s2_slot;
            s2_div_w_reg <= s2_div_w;
            s2_div_h_reg <= s2_div_h;
            s2_gw_reg    <= s1_gw_reg;
        end
    end

    // Divider stages; the payload travels alongside, and the flat index is formed in the
    // first of them.
    atac_pkg::div_t  div_w [D+1];
    atac_pkg::div_t  div_h [D+1];
    atac_pkg::slot_t pay_reg [D];
    atac_pkg::slot_t pay_in;
    logic [D-1:0]    pv_reg;

    assign div_w[0] = s2_div_w_reg;
    assign div_h[0] = s2_div_h_reg;

    for (genvar i = 0; i < D; i++)
    begin : g_div
        atac_div_stage u_div_w (
            .clk    (clk),
            .adv    (adv),
            .div_in (div_w[i]),
            .div_out(div_w[i+1])
        );
        atac_div_stage u_div_h (
            .clk    (clk),
            .adv    (adv),
            .div_in (div_h[i]),
            .div_out(div_h[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= '0;
        else if (adv)
            pv_reg <= {pv_reg[D-2:0], s2_valid_reg};
    end

    always_comb
    begin
        pay_in      = s2_slot_reg;
        pay_in.flat = 24'(s2_slot_reg.row * s2_gw_reg + 25'(s2_slot_reg.cell_x));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pay_reg[0] <= pay_in;
            for (int i = 1; i < D; i++)
                pay_reg[i] <= pay_reg[i-1];
        end
    end

    // Output register: only words of passing anchors with a batch index in range are marked valid.
    atac_pkg::slot_t out_slot_reg;
    logic [14:0]     out_rw_reg, out_rh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= pv_reg[D-1] && pay_reg[D-1].keep;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_slot_reg <= pay_reg[D-1];
            out_rw_reg   <= (div_w[D].ovf || div_w[D].quo[15]) ? atac_pkg::RATIO_MAX
                                                               : div_w[D].quo[14:0];
            out_rh_reg   <= (div_h[D].ovf || div_h[D].quo[15]) ? atac_pkg::RATIO_MAX
                                                               : div_h[D].quo[14:0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign anchor_index = out_slot_reg.anchor;
    assign cell_x       = out_slot_reg.cell_x;
    assign cell_y       = out_slot_reg.cell_y;
    assign flat_index   = out_slot_reg.flat;
    assign offset_x     = out_slot_reg.off_x;
    assign offset_y     = out_slot_reg.off_y;
    assign width_ratio  = out_rw_reg;
    assign height_ratio = out_rh_reg;
    assign class_out    = out_slot_reg.cls;
    assign class_valid  = out_slot_reg.cls_ok;
    assign last         = out_slot_reg.last;

endmodule
